/* src/tsad_pkg.sv */
// tsad_pkg: constants shared by the transport stream audio demux
// no dependencies
package tsad_pkg;
    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] PACKET_BYTES = 8'd188;
    localparam logic [8:0] OFFSET_PEND  = 9'h1FF;
    localparam logic [7:0] PAT_TABLE_ID = 8'h00;
    localparam logic [7:0] PMT_TABLE_ID = 8'h02;
    localparam logic [7:0] ST_AAC       = 8'h0F;
    localparam logic [7:0] ST_MPA1      = 8'h03;
    localparam logic [7:0] ST_MPA2      = 8'h04;
    localparam logic [1:0] AFC_ADAPT    = 2'd2;
    localparam logic [1:0] AFC_BOTH     = 2'd3;
endpackage

/* src/ts_audio_demux.sv */
// ts_audio_demux: byte-wide transport stream parser that extracts one audio stream
// depends on tsad_pkg
// output: a payload word appears on m_ in the cycle after it is accepted on s_
// throughput: one word per cycle unless m_tready stalls; per-byte header, table
// and pes parsing is one compare and counter pass before the output register
// reset: synchronous active-low aresetn clears all parser state; no clearing pass
module ts_audio_demux import tsad_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] stream_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] audio_byte
    output logic       m_tuser    // [0] audio_kind
);
    logic        in_packet_reg, in_packet_next;
    logic [7:0]  pos_reg, pos_next;
    logic [12:0] pid_reg, pid_next;
    logic        ustart_reg, ustart_next;
    logic [1:0]  afc_reg, afc_next;
    logic [8:0]  poff_reg, poff_next;
    logic        skip_reg, skip_next;
    logic [8:0]  sec_start_reg, sec_start_next;
    logic [11:0] sec_len_reg, sec_len_next;
    logic        matched_reg, matched_next;
    logic [11:0] pil_reg, pil_next;
    logic [13:0] cursor_reg, cursor_next;
    logic [31:0] entry_reg, entry_next;
    logic [11:0] dlen_reg, dlen_next;
    logic [12:0] pmt_pid_reg, pmt_pid_next;
    logic        pmt_known_reg, pmt_known_next;
    logic [12:0] aud_pid_reg, aud_pid_next;
    logic        aud_known_reg, aud_known_next;
    logic        codec_reg, codec_next;
    logic        pes_ok_reg, pes_ok_next;
    logic [7:0]  pes_hlen_reg, pes_hlen_next;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_kind_reg;

    logic        take, emit;
    logic [7:0]  b;
    logic [8:0]  j;       // payload index
    logic [8:0]  s;       // section index
    logic [13:0] d;
    logic [7:0]  kind;
    logic [11:0] dl_full;
    logic        is_pmt;
    logic        tbl;

    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    always_comb begin
        in_packet_next = in_packet_reg; pos_next = pos_reg; pid_next = pid_reg;
        ustart_next = ustart_reg; afc_next = afc_reg; poff_next = poff_reg;
        skip_next = skip_reg; sec_start_next = sec_start_reg; sec_len_next = sec_len_reg;
        matched_next = matched_reg; pil_next = pil_reg; cursor_next = cursor_reg;
        entry_next = entry_reg; dlen_next = dlen_reg; pmt_pid_next = pmt_pid_reg;
        pmt_known_next = pmt_known_reg; aud_pid_next = aud_pid_reg;
        aud_known_next = aud_known_reg; codec_next = codec_reg;
        pes_ok_next = pes_ok_reg; pes_hlen_next = pes_hlen_reg;
        emit = 1'b0;
        j = {1'b0, pos_reg} - poff_reg;
        s = j - sec_start_reg;
        d = {5'd0, s} - cursor_reg;
        kind = entry_reg[23:16];
        dl_full = {dlen_reg[11:8], b};
        is_pmt = pmt_known_reg;
        tbl = 1'b0;
        if (!in_packet_reg) begin
            if (b == SYNC_BYTE) begin
                in_packet_next = 1'b1; pos_next = 8'd1; pid_next = '0;
                ustart_next = 1'b0; afc_next = '0; poff_next = 9'd4;
                skip_next = 1'b0; matched_next = 1'b0; pes_ok_next = 1'b0;
            end
        end else begin
            if (pos_reg == 8'd1) begin
                ustart_next = b[6];
                pid_next = {b[4:0], 8'd0};
            end else if (pos_reg == 8'd2) begin
                pid_next = {pid_reg[12:8], b};
            end else if (pos_reg == 8'd3) begin
                afc_next = b[5:4];
                if (b[5:4] == AFC_ADAPT) skip_next = 1'b1;
                else if (b[5:4] == AFC_BOTH) poff_next = OFFSET_PEND;
                else poff_next = 9'd4;
            end else if (pos_reg == 8'd4 && afc_reg == AFC_BOTH) begin
                poff_next = 9'd5 + {1'b0, b};
                if (9'd5 + {1'b0, b} > {1'b0, PACKET_BYTES}) skip_next = 1'b1;
            end else if (pos_reg >= 8'd4 && !skip_reg && {1'b0, pos_reg} >= poff_reg) begin
                if (aud_known_reg) begin
                    if (pid_reg == aud_pid_reg) begin
                        if (!ustart_reg) emit = 1'b1;
                        else if (j == 9'd0 || j == 9'd1) begin
                            if (b != 8'h00) skip_next = 1'b1;
                        end else if (j == 9'd2) begin
                            if (b != 8'h01) skip_next = 1'b1;
                            else pes_ok_next = 1'b1;
                        end else if (j == 9'd8) begin
                            pes_hlen_next = b;
                        end else if (j >= 9'd9 && pes_ok_reg
                                     && (j - 9'd9) >= {1'b0, pes_hlen_reg}) begin
                            emit = 1'b1;
                        end
                    end
                end else if (ustart_reg) begin
                    tbl = pmt_known_reg ? (pid_reg == pmt_pid_reg) : (pid_reg == 13'd0);
                end
            end
            if (tbl) begin
                if (j == 9'd0) begin
                    sec_start_next = 9'd1 + {1'b0, b};
                end else if (j >= sec_start_reg) begin
                    if (s == 9'd0) begin
                        if (b != (is_pmt ? PMT_TABLE_ID : PAT_TABLE_ID)) skip_next = 1'b1;
                        else matched_next = 1'b1;
                    end else if (s == 9'd1) begin
                        sec_len_next = {b[3:0], 8'd0};
                    end else if (s == 9'd2) begin
                        sec_len_next = {sec_len_reg[11:8], b};
                    end else if (!is_pmt) begin
                        if (s >= 9'd8) begin
                            entry_next = {entry_reg[23:0], b};
                            if (s[1:0] == 2'd3) begin
                                if ({3'd0, s} + 12'd2 > sec_len_reg) skip_next = 1'b1;
                                else if (entry_reg[23:8] != 16'd0) begin
                                    pmt_pid_next = {entry_reg[4:0], b};
                                    pmt_known_next = 1'b1;
                                    skip_next = 1'b1;
                                end
                            end
                        end
                    end else if (s == 9'd10) begin
                        pil_next = {b[3:0], 8'd0};
                    end else if (s == 9'd11) begin
                        pil_next = {pil_reg[11:8], b};
                        cursor_next = 14'd12 + {2'd0, pil_reg[11:8], b};
                    end else if (s >= 9'd12 && {5'd0, s} >= cursor_reg) begin
                        if (d == 14'd0) begin
                            if ({1'b0, cursor_reg} + 15'd6 > {3'd0, sec_len_reg})
                                skip_next = 1'b1;
                            else entry_next = {24'd0, b};
                        end else if (d == 14'd1 || d == 14'd2) begin
                            entry_next = {entry_reg[23:0], b};
                        end else if (d == 14'd3) begin
                            dlen_next = {b[3:0], 8'd0};
                        end else begin
                            dlen_next = dl_full;
                            if (kind == ST_AAC || kind == ST_MPA1 || kind == ST_MPA2) begin
                                aud_pid_next = entry_reg[12:0];
                                codec_next = (kind != ST_AAC);
                                aud_known_next = 1'b1;
                                skip_next = 1'b1;
                            end else begin
                                cursor_next = cursor_reg + 14'd5 + {2'd0, dl_full};
                            end
                        end
                    end
                end
            end
            if (pos_reg + 8'd1 >= PACKET_BYTES) begin
                in_packet_next = 1'b0; pos_next = 8'd0;
            end else begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0; pos_reg <= '0; pid_reg <= '0; ustart_reg <= 1'b0;
            afc_reg <= '0; poff_reg <= 9'd4; skip_reg <= 1'b0; sec_start_reg <= '0;
            sec_len_reg <= '0; matched_reg <= 1'b0; pil_reg <= '0; cursor_reg <= '0;
            entry_reg <= '0; dlen_reg <= '0; pmt_pid_reg <= '0; pmt_known_reg <= 1'b0;
            aud_pid_reg <= '0; aud_known_reg <= 1'b0; codec_reg <= 1'b0;
            pes_ok_reg <= 1'b0; pes_hlen_reg <= '0; m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_packet_reg <= in_packet_next; pos_reg <= pos_next; pid_reg <= pid_next;
                ustart_reg <= ustart_next; afc_reg <= afc_next; poff_reg <= poff_next;
                skip_reg <= skip_next; sec_start_reg <= sec_start_next;
                sec_len_reg <= sec_len_next; matched_reg <= matched_next;
                pil_reg <= pil_next; cursor_reg <= cursor_next; entry_reg <= entry_next;
                dlen_reg <= dlen_next; pmt_pid_reg <= pmt_pid_next;
                pmt_known_reg <= pmt_known_next; aud_pid_reg <= aud_pid_next;
                aud_known_reg <= aud_known_next; codec_reg <= codec_next;
                pes_ok_reg <= pes_ok_next; pes_hlen_reg <= pes_hlen_next;
            end
            if (s_tready) m_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            m_data_reg <= b;
            m_kind_reg <= codec_reg;
        end
    end
endmodule
